@@ sv/adjacency_graph_dfs_engine_macros.svh @@
// Assertion macros for the graph search engine checker.
// Used by adjacency_graph_dfs_engine_chk only; no other dependencies.
`ifndef ADJACENCY_GRAPH_DFS_ENGINE_MACROS_SVH
`define ADJACENCY_GRAPH_DFS_ENGINE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define AGD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define AGD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/agd_pkg.sv @@
// Shared types and constants for the graph search engine.
// No dependencies.
package agd_pkg;
  localparam int NODE_SLOTS_DEF  = 64;
  localparam int ID_BITS_DEF     = 16;
  localparam int STACK_DEPTH_DEF = 256;

  // request codes
  localparam logic [2:0] REQ_ADD_NODE = 3'd0;
  localparam logic [2:0] REQ_ADD_EDGE = 3'd1;
  localparam logic [2:0] REQ_TEST     = 3'd2;
  localparam logic [2:0] REQ_SEARCH   = 3'd3;
  localparam logic [2:0] REQ_PRED     = 3'd4;
  localparam logic [2:0] REQ_DEGREE   = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,     // waiting for a word
    S_LOOKUP,   // scan id table, one slot a cycle
    S_DECIDE,   // classify request
    S_CLEAR,    // clear column of new node, one row a cycle
    S_RDROW,    // read adjacency row of an operand
    S_EXEC,     // finish simple request
    S_POP,      // pop a stack entry
    S_POPRD,    // stack read data returns
    S_SCAN,     // walk neighbors, one slot a cycle
    S_RESULT    // hand result to output register
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic lookup_start;
    logic lookup_step;
    logic add_node;
    logic clear_step;
    logic row_read;
    logic exec;
    logic push_start;
    logic pop;
    logic pop_apply;
    logic scan_step;
    logic set_status;
    logic [2:0] status_code;
    logic set_flag;
    logic emit;
  } agd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] req;
    logic lookup_done;
    logic a_found;
    logic b_found;
    logic full;
    logic clear_done;
    logic stack_empty;
    logic entry_marked;
    logic scan_done;
    logic scan_hit_target;
    logic scan_overflow;
    logic out_busy;
  } agd_sts_t;
endpackage

@@ sv/adjacency_graph_dfs_engine.sv @@
// Top level of the graph search engine.
// Depends on agd_pkg, agd_ctrl and agd_datapath.
//
// Input channel in_*: one word per request (type, first id, second id),
// accepted when in_valid is high and in_stall low. Output channel out_*:
// one result word per request, taken when out_valid is high and out_stall low.
// A request runs alone: in_stall is high from acceptance until its result is
// loaded into the output register, so the next word can be taken while that
// result still waits on a stalled receiver.
// An id lookup scans the id table one slot a cycle over the stored nodes. Adding
// a node sweeps all NODE_SLOTS rows to clear its column. A search pops stack
// entries and walks each expanded node's row one slot a cycle on top of the
// lookup. After the result is loaded the engine returns to idle and can take
// the next word.
// Reset (rst_n low, synchronous) empties the graph, the stack and the output.
// While the receiver stalls, the result holds and the engine waits in its
// result state.
module adjacency_graph_dfs_engine #(
  parameter int NODE_SLOTS  = agd_pkg::NODE_SLOTS_DEF,
  parameter int ID_BITS     = agd_pkg::ID_BITS_DEF,
  parameter int STACK_DEPTH = agd_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_first_id,
  input  logic [15:0] in_second_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_answer_flag,
  output logic [15:0] out_answer_id,
  output logic [6:0]  out_out_degree,
  output logic [6:0]  out_node_total,
  output logic [12:0] out_edge_total
);
  agd_pkg::agd_cmd_t cmd;
  agd_pkg::agd_sts_t sts;

  agd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  agd_datapath #(
    .NODE_SLOTS(NODE_SLOTS), .ID_BITS(ID_BITS), .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_req_type(in_req_type), .in_first_id(in_first_id), .in_second_id(in_second_id),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_answer_flag(out_answer_flag),
    .out_answer_id(out_answer_id), .out_out_degree(out_out_degree),
    .out_node_total(out_node_total), .out_edge_total(out_edge_total)
  );
endmodule

@@ sv/agd_ctrl.sv @@
// Controller state machine for the graph search engine.
// Depends on agd_pkg.
module agd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  agd_pkg::agd_sts_t sts,
  output agd_pkg::agd_cmd_t cmd
);
  agd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= agd_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      agd_pkg::S_IDLE:   if (in_valid) state_nxt = agd_pkg::S_LOOKUP;
      agd_pkg::S_LOOKUP: if (sts.lookup_done) state_nxt = agd_pkg::S_DECIDE;
      agd_pkg::S_DECIDE: begin
        if (sts.req == agd_pkg::REQ_ADD_NODE) begin
          if (sts.a_found || sts.full) state_nxt = agd_pkg::S_RESULT;
          else state_nxt = agd_pkg::S_CLEAR;
        end else if (sts.req > agd_pkg::REQ_DEGREE) begin
          state_nxt = agd_pkg::S_RESULT;
        end else if (!sts.a_found || (sts.req <= agd_pkg::REQ_SEARCH && !sts.b_found)) begin
          state_nxt = agd_pkg::S_RESULT;
        end else if (sts.req == agd_pkg::REQ_SEARCH) begin
          state_nxt = agd_pkg::S_POP;
        end else begin
          state_nxt = agd_pkg::S_RDROW;
        end
      end
      agd_pkg::S_CLEAR:  if (sts.clear_done) state_nxt = agd_pkg::S_RESULT;
      agd_pkg::S_RDROW:  state_nxt = agd_pkg::S_EXEC;
      agd_pkg::S_EXEC:   state_nxt = agd_pkg::S_RESULT;
      agd_pkg::S_POP: begin
        if (sts.stack_empty) state_nxt = agd_pkg::S_RESULT;
        else state_nxt = agd_pkg::S_POPRD;
      end
      agd_pkg::S_POPRD: begin
        if (sts.entry_marked) state_nxt = agd_pkg::S_POP;
        else state_nxt = agd_pkg::S_SCAN;
      end
      agd_pkg::S_SCAN: begin
        if (sts.scan_hit_target || sts.scan_overflow) state_nxt = agd_pkg::S_RESULT;
        else if (sts.scan_done) state_nxt = agd_pkg::S_POP;
      end
      agd_pkg::S_RESULT: if (!sts.out_busy) state_nxt = agd_pkg::S_IDLE;
      default: state_nxt = agd_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = (state_r != agd_pkg::S_IDLE);
    case (state_r)
      agd_pkg::S_IDLE: begin
        cmd.load_req = in_valid;
        cmd.lookup_start = in_valid;
      end
      agd_pkg::S_LOOKUP: cmd.lookup_step = 1'b1;
      agd_pkg::S_DECIDE: begin
        if (sts.req == agd_pkg::REQ_ADD_NODE) begin
          if (sts.a_found) begin
            cmd.set_status = 1'b1; cmd.status_code = agd_pkg::ST_DUP;
          end else if (sts.full) begin
            cmd.set_status = 1'b1; cmd.status_code = agd_pkg::ST_FULL;
          end else begin
            cmd.add_node = 1'b1;
          end
        end else if (sts.req <= agd_pkg::REQ_DEGREE && (!sts.a_found ||
                     (sts.req <= agd_pkg::REQ_SEARCH && !sts.b_found))) begin
          cmd.set_status = 1'b1; cmd.status_code = agd_pkg::ST_UNKNOWN;
        end else if (sts.req == agd_pkg::REQ_SEARCH) begin
          cmd.push_start = 1'b1;
        end else if (sts.req <= agd_pkg::REQ_DEGREE) begin
          cmd.row_read = 1'b1;
        end
      end
      agd_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      agd_pkg::S_EXEC:  cmd.exec = 1'b1;
      agd_pkg::S_POP:   cmd.pop = !sts.stack_empty;
      agd_pkg::S_POPRD: cmd.pop_apply = 1'b1;
      agd_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit_target) cmd.set_flag = 1'b1;
        else if (sts.scan_overflow) begin
          cmd.set_status = 1'b1; cmd.status_code = agd_pkg::ST_OVERFLOW;
        end
      end
      agd_pkg::S_RESULT: cmd.emit = !sts.out_busy;
      default: ;
    endcase
  end
endmodule

@@ sv/agd_datapath.sv @@
// Datapath of the graph search engine: node tables, adjacency rows, stack, result.
// Depends on agd_pkg.
module agd_datapath #(
  parameter int NODE_SLOTS  = agd_pkg::NODE_SLOTS_DEF,
  parameter int ID_BITS     = agd_pkg::ID_BITS_DEF,
  parameter int STACK_DEPTH = agd_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_req_type,
  input  logic [15:0]         in_first_id,
  input  logic [15:0]         in_second_id,
  input  agd_pkg::agd_cmd_t   cmd,
  output agd_pkg::agd_sts_t   sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic                out_answer_flag,
  output logic [15:0]         out_answer_id,
  output logic [6:0]          out_out_degree,
  output logic [6:0]          out_node_total,
  output logic [12:0]         out_edge_total
);
  localparam int SW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CW = $clog2(NODE_SLOTS + 1);
  localparam int KW = $clog2(STACK_DEPTH + 1);
  localparam int PW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int EW = $clog2(NODE_SLOTS * NODE_SLOTS + 1);
  localparam int IW = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int STKW = SW + SW + 2;

  // memories
  logic [ID_BITS-1:0]    id_mem    [NODE_SLOTS];
  logic [NODE_SLOTS-1:0] adj_mem   [NODE_SLOTS];
  logic [CW-1:0]         deg_mem   [NODE_SLOTS];
  logic [SW-1:0]         pred_mem  [NODE_SLOTS];
  logic [STKW-1:0]       stack_mem [STACK_DEPTH];
  // per-slot flags in flip-flops
  logic [NODE_SLOTS-1:0] mark_r, pvalid_r;

  logic [2:0]         req_r;
  logic [ID_BITS-1:0] a_id_r, b_id_r;
  logic [SW-1:0]      a_slot_r, b_slot_r;
  logic               a_found_r, b_found_r;
  logic [CW-1:0]      node_cnt_r;
  logic [EW-1:0]      edge_cnt_r;
  logic [CW-1:0]      idx_r;
  logic [ID_BITS-1:0] id_rd_r;
  logic               id_rd_ok_r;
  logic [CW-1:0]      id_rd_idx_r;
  logic [NODE_SLOTS-1:0] row_r;
  logic [CW-1:0]      deg_rd_r;
  logic [SW-1:0]      pred_rd_r;
  logic [KW-1:0]      sp_r;
  logic [STKW-1:0]    pop_rd_r;
  logic [SW-1:0]      cur_r;
  logic [CW-1:0]      scan_r;
  logic [2:0]         status_r;
  logic               flag_r;

  // id table: read one slot a cycle during lookup, written on add
  logic [ID_BITS-1:0] a_in, b_in;
  assign a_in = ID_BITS'({16'd0, in_first_id});
  assign b_in = ID_BITS'({16'd0, in_second_id});

  logic [SW-1:0] id_rd_addr;
  always_comb begin
    id_rd_addr = idx_r[SW-1:0];
    if (cmd.exec) id_rd_addr = pred_rd_r;
  end

  // read data holds after execute so the predecessor id survives a result wait
  always_ff @(posedge clk) begin
    if (cmd.add_node) id_mem[node_cnt_r[SW-1:0]] <= a_id_r;
    if (cmd.lookup_step || cmd.exec) id_rd_r <= id_mem[id_rd_addr];
  end

  // lookup scan: index idx_r issued, data arrives next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_rd_ok_r <= 1'b0;
    end else if (cmd.lookup_start) begin
      id_rd_ok_r <= 1'b0;
    end else if (cmd.lookup_step) begin
      id_rd_ok_r <= (idx_r < node_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r  <= in_req_type;
      a_id_r <= a_in;
      b_id_r <= b_in;
    end
    if (cmd.lookup_start) begin
      idx_r <= '0;
      a_found_r <= 1'b0;
      b_found_r <= 1'b0;
    end else if (cmd.lookup_step) begin
      if (idx_r < node_cnt_r) idx_r <= idx_r + CW'(1);
      id_rd_idx_r <= idx_r;
      if (id_rd_ok_r) begin
        if (!a_found_r && id_rd_r == a_id_r) begin
          a_found_r <= 1'b1; a_slot_r <= id_rd_idx_r[SW-1:0];
        end
        if (!b_found_r && id_rd_r == b_id_r) begin
          b_found_r <= 1'b1; b_slot_r <= id_rd_idx_r[SW-1:0];
        end
      end
    end else if (cmd.add_node) begin
      idx_r <= '0;
    end else if (cmd.clear_step) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // lookup is done once the index passed the count and the last data is checked
  assign sts.lookup_done = (idx_r >= node_cnt_r) && !id_rd_ok_r && cmd.lookup_step;

  // adjacency rows: one read port, one write port
  logic               adj_we;
  logic [SW-1:0]      adj_waddr;
  logic [NODE_SLOTS-1:0] adj_wdata;
  logic [SW-1:0]      adj_raddr;
  logic [SW-1:0]      new_slot;
  assign new_slot = node_cnt_r[SW-1:0];

  always_comb begin
    adj_we = 1'b0;
    adj_waddr = a_slot_r;
    adj_wdata = row_r;
    adj_raddr = a_slot_r;
    if (cmd.add_node) begin
      adj_we = 1'b1; adj_waddr = new_slot; adj_wdata = '0;
    end else if (cmd.clear_step) begin
      adj_we = 1'b1; adj_waddr = idx_r[SW-1:0];
      adj_wdata = row_r;
      adj_wdata[new_slot] = 1'b0;
      // the new node's own row is cleared whole
      if (idx_r[SW-1:0] == new_slot) adj_wdata = '0;
    end else if (cmd.exec && req_r == agd_pkg::REQ_ADD_EDGE && !row_r[b_slot_r]) begin
      adj_we = 1'b1; adj_waddr = a_slot_r;
      adj_wdata = row_r;
      adj_wdata[b_slot_r] = 1'b1;
    end
    if (cmd.add_node) adj_raddr = '0;
    else if (cmd.clear_step) adj_raddr = idx_r[SW-1:0] + SW'(1);
    else if (cmd.pop_apply) adj_raddr = pop_rd_r[STKW-1 -: SW];
    else if (cmd.scan_step) adj_raddr = cur_r;
  end

  // clearing: row idx is read in the cycle before its write-back
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    row_r <= adj_mem[adj_raddr];
  end

  assign sts.clear_done = cmd.clear_step && (idx_r == CW'(NODE_SLOTS - 1));

  // degree and predecessor tables
  always_ff @(posedge clk) begin
    if (cmd.add_node) deg_mem[new_slot] <= '0;
    else if (cmd.exec && req_r == agd_pkg::REQ_ADD_EDGE && !row_r[b_slot_r])
      deg_mem[a_slot_r] <= deg_rd_r + CW'(1);
    deg_rd_r <= deg_mem[a_slot_r];
  end

  logic          pred_we;
  logic [SW-1:0] pred_waddr, pred_wdata;
  always_comb begin
    pred_we = 1'b0; pred_waddr = cur_r; pred_wdata = cur_r;
    if (cmd.pop_apply && !pop_rd_r[0]) begin
      pred_we = 1'b1; pred_waddr = pop_rd_r[STKW-1 -: SW];
      pred_wdata = pop_rd_r[SW+1:2];
    end else if (cmd.scan_step && scan_r < node_cnt_r && row_r[scan_r[SW-1:0]] &&
                 (scan_r[SW-1:0] == b_slot_r || !mark_r[scan_r[SW-1:0]])) begin
      pred_we = 1'b1; pred_waddr = scan_r[SW-1:0]; pred_wdata = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pred_we) pred_mem[pred_waddr] <= pred_wdata;
    pred_rd_r <= pred_mem[a_slot_r];
  end

  // marks and predecessor-valid flags
  logic scan_hit;
  assign scan_hit = cmd.scan_step && scan_r < node_cnt_r && row_r[scan_r[SW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= '0;
      pvalid_r <= '0;
    end else begin
      if (cmd.add_node) begin
        mark_r[new_slot] <= 1'b0;
        pvalid_r[new_slot] <= 1'b0;
      end
      if (cmd.pop_apply && !pop_rd_r[0]) begin
        mark_r[pop_rd_r[STKW-1 -: SW]] <= 1'b1;
        pvalid_r[pop_rd_r[STKW-1 -: SW]] <= pop_rd_r[1];
      end
      if (scan_hit && (scan_r[SW-1:0] == b_slot_r || !mark_r[scan_r[SW-1:0]]))
        pvalid_r[scan_r[SW-1:0]] <= 1'b1;
    end
  end

  // search stack: entry is {slot, pred, pred_ok, mark}
  logic            stk_we;
  logic [PW-1:0]   stk_waddr;
  logic [STKW-1:0] stk_wdata;
  always_comb begin
    stk_we = 1'b0; stk_waddr = sp_r[PW-1:0];
    stk_wdata = {scan_r[SW-1:0], cur_r, 1'b1, 1'b0};
    if (cmd.push_start) begin
      stk_we = 1'b1; stk_waddr = '0;
      stk_wdata = {a_slot_r, pred_rd_r, pvalid_r[a_slot_r], mark_r[a_slot_r]};
    end else if (scan_hit && scan_r[SW-1:0] != b_slot_r && !mark_r[scan_r[SW-1:0]] &&
                 sp_r < KW'(STACK_DEPTH)) begin
      stk_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    pop_rd_r <= stack_mem[sp_r[PW-1:0] - PW'(1)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sp_r <= '0;
    else if (cmd.push_start) sp_r <= KW'(1);
    else if (cmd.pop) sp_r <= sp_r - KW'(1);
    else if (stk_we) sp_r <= sp_r + KW'(1);
  end

  // neighbor walk
  always_ff @(posedge clk) begin
    if (cmd.pop_apply) begin
      cur_r <= pop_rd_r[STKW-1 -: SW];
      scan_r <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + CW'(1);
    end
  end

  assign sts.req = req_r;
  assign sts.a_found = a_found_r;
  assign sts.b_found = b_found_r;
  assign sts.full = (node_cnt_r >= CW'(NODE_SLOTS));
  assign sts.stack_empty = (sp_r == '0);
  assign sts.entry_marked = pop_rd_r[0];
  assign sts.scan_done = scan_r >= node_cnt_r;
  assign sts.scan_hit_target = scan_hit && scan_r[SW-1:0] == b_slot_r;
  assign sts.scan_overflow = scan_hit && scan_r[SW-1:0] != b_slot_r &&
                             !mark_r[scan_r[SW-1:0]] && sp_r >= KW'(STACK_DEPTH);
  assign sts.out_busy = out_valid && out_stall;

  // status, flag and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r <= '0;
      edge_cnt_r <= '0;
    end else begin
      if (sts.clear_done) node_cnt_r <= node_cnt_r + CW'(1);
      if (cmd.exec && req_r == agd_pkg::REQ_ADD_EDGE && !row_r[b_slot_r])
        edge_cnt_r <= edge_cnt_r + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      status_r <= agd_pkg::ST_OK;
      flag_r <= 1'b0;
    end else begin
      if (cmd.set_status) status_r <= cmd.status_code;
      if (cmd.set_flag) flag_r <= 1'b1;
      if (cmd.exec && req_r == agd_pkg::REQ_TEST) flag_r <= row_r[b_slot_r];
      if (cmd.exec && req_r == agd_pkg::REQ_PRED) flag_r <= pvalid_r[a_slot_r];
    end
  end

  // output register, loaded on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= status_r;
      out_answer_flag <= flag_r;
      out_answer_id <= '0;
      out_out_degree <= '0;
      if (status_r == agd_pkg::ST_OK && flag_r && req_r == agd_pkg::REQ_PRED)
        out_answer_id <= 16'(id_rd_r[IW-1:0]);
      if (status_r == agd_pkg::ST_OK && req_r == agd_pkg::REQ_DEGREE)
        out_out_degree <= 7'(deg_rd_r);
      out_node_total <= 7'(node_cnt_r);
      out_edge_total <= 13'(edge_cnt_r);
    end
  end
endmodule

@@ sv/adjacency_graph_dfs_engine_chk.sv @@
// Port checker for the graph search engine, bound to the top level.
// Depends on adjacency_graph_dfs_engine_macros.svh and agd_pkg.
`include "adjacency_graph_dfs_engine_macros.svh"
module adjacency_graph_dfs_engine_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic        out_answer_flag,
  input logic [6:0]  out_node_total
);
  `AGD_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_status <= agd_pkg::ST_OVERFLOW, "status out of range")
  `AGD_ASSERT_IMP(a_flag_ok, clk, rst_n, out_valid && out_answer_flag, out_status == agd_pkg::ST_OK, "flag with error status")
  `AGD_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "second word taken while busy")
  `AGD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_node_total), "stalled word changed")
endmodule

bind adjacency_graph_dfs_engine adjacency_graph_dfs_engine_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_answer_flag(out_answer_flag), .out_node_total(out_node_total)
);

@@ sim/testbench.sv @@
// Self-checking testbench for adjacency_graph_dfs_engine: directed requests, then random ones.
// Depends on agd_pkg and the engine RTL; a built-in graph predictor supplies the expected words.
`timescale 1ns / 100ps

module testbench;
  localparam int SLOTS = agd_pkg::NODE_SLOTS_DEF;
  localparam int DEPTH = agd_pkg::STACK_DEPTH_DEF;
  localparam int MAX_CYCLES = 20000000;
  // request codes the engine does not implement
  localparam logic [2:0] REQ_BAD_A = 3'd6;
  localparam logic [2:0] REQ_BAD_B = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic        flag;
    logic [15:0] ans;
    logic [6:0]  deg;
    logic [6:0]  nodes;
    logic [12:0] edges;
  } graph_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_req_type = '0;
  logic [15:0] in_first_id = '0;
  logic [15:0] in_second_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic out_answer_flag;
  logic [15:0] out_answer_id;
  logic [6:0] out_out_degree;
  logic [6:0] out_node_total;
  logic [12:0] out_edge_total;

  adjacency_graph_dfs_engine uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the graph
  logic [15:0] ids [SLOTS];
  logic [SLOTS-1:0] rows [SLOTS];
  logic [6:0] degs [SLOTS];
  logic [SLOTS-1:0] marks;
  logic [6:0] preds [SLOTS];
  logic [SLOTS-1:0] pred_ok;
  int node_cnt;
  int edge_cnt;

  graph_reply_t pending_replies[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit rx_random = 1'b1;

  function automatic int find_slot(logic [15:0] id);
    for (int i = 0; i < node_cnt; i++)
      if (ids[i] == id) return i;
    return -1;
  endfunction

  // depth-first walk; 0 not found, 1 found, 2 overflow
  function automatic int walk_graph(int start, int target);
    int sp;
    int st_slot [DEPTH];
    int st_pred [DEPTH];
    bit st_pok [DEPTH];
    bit st_mark [DEPTH];
    int cur, cp;
    bit cpok;
    sp = 1;
    st_slot[0] = start;
    st_pred[0] = preds[start];
    st_pok[0] = pred_ok[start];
    st_mark[0] = marks[start];
    while (sp > 0) begin
      sp--;
      cur = st_slot[sp];
      cp = st_pred[sp];
      cpok = st_pok[sp];
      if (st_mark[sp]) continue;
      marks[cur] = 1'b1;
      preds[cur] = cp[6:0];
      pred_ok[cur] = cpok;
      for (int j = 0; j < node_cnt; j++) begin
        if (!rows[cur][j]) continue;
        if (j == target) begin
          preds[j] = cur[6:0];
          pred_ok[j] = 1'b1;
          return 1;
        end
        if (!marks[j]) begin
          preds[j] = cur[6:0];
          pred_ok[j] = 1'b1;
          if (sp >= DEPTH) return 2;
          st_slot[sp] = j;
          st_pred[sp] = cur;
          st_pok[sp] = 1'b1;
          st_mark[sp] = 1'b0;
          sp++;
        end
      end
    end
    return 0;
  endfunction

  function automatic graph_reply_t predict_reply(logic [2:0] req, logic [15:0] a,
                                                 logic [15:0] b);
    graph_reply_t r;
    int sa, sb, w;
    r = '0;
    if (req <= agd_pkg::REQ_DEGREE) begin
      sa = find_slot(a);
      sb = find_slot(b);
      if (req == agd_pkg::REQ_ADD_NODE) begin
        if (sa >= 0) r.status = agd_pkg::ST_DUP;
        else if (node_cnt >= SLOTS) r.status = agd_pkg::ST_FULL;
        else begin
          ids[node_cnt] = a;
          rows[node_cnt] = '0;
          for (int k = 0; k < SLOTS; k++) rows[k][node_cnt] = 1'b0;
          degs[node_cnt] = '0;
          marks[node_cnt] = 1'b0;
          pred_ok[node_cnt] = 1'b0;
          preds[node_cnt] = '0;
          node_cnt++;
        end
      end else if (sa < 0 || ((req == agd_pkg::REQ_ADD_EDGE || req == agd_pkg::REQ_TEST ||
                               req == agd_pkg::REQ_SEARCH) && sb < 0)) begin
        r.status = agd_pkg::ST_UNKNOWN;
      end else if (req == agd_pkg::REQ_ADD_EDGE) begin
        if (!rows[sa][sb]) begin
          rows[sa][sb] = 1'b1;
          degs[sa]++;
          edge_cnt++;
        end
      end else if (req == agd_pkg::REQ_TEST) begin
        r.flag = rows[sa][sb];
      end else if (req == agd_pkg::REQ_SEARCH) begin
        w = walk_graph(sa, sb);
        if (w == 1) r.flag = 1'b1;
        else if (w == 2) r.status = agd_pkg::ST_OVERFLOW;
      end else if (req == agd_pkg::REQ_PRED) begin
        if (pred_ok[sa]) begin
          r.flag = 1'b1;
          r.ans = ids[preds[sa] % SLOTS];
        end
      end else begin
        r.deg = degs[sa];
      end
    end
    r.nodes = node_cnt[6:0];
    r.edges = edge_cnt[12:0];
    return r;
  endfunction

  // send one word, with a random gap before it; valid drops only in a gap
  task automatic send_word(logic [2:0] req, logic [15:0] a, logic [15:0] b);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_first_id <= a;
    in_second_id <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_replies.push_back(predict_reply(req, a, b));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    graph_reply_t exp_r;
    graph_reply_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_answer_flag, out_answer_id, out_out_degree,
             out_node_total, out_edge_total};
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, got);
        errors++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (got.status != exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, got.status);
          errors++;
        end
        if (got.flag != exp_r.flag) begin
          $display("%0t: flag exp %0d got %0d", $realtime, exp_r.flag, got.flag);
          errors++;
        end
        if (got.ans != exp_r.ans) begin
          $display("%0t: answer_id exp %h got %h", $realtime, exp_r.ans, got.ans);
          errors++;
        end
        if (got.deg != exp_r.deg) begin
          $display("%0t: out_degree exp %0d got %0d", $realtime, exp_r.deg, got.deg);
          errors++;
        end
        if (got.nodes != exp_r.nodes) begin
          $display("%0t: node_total exp %0d got %0d", $realtime, exp_r.nodes, got.nodes);
          errors++;
        end
        if (got.edges != exp_r.edges) begin
          $display("%0t: edge_total exp %0d got %0d", $realtime, exp_r.edges, got.edges);
          errors++;
        end
      end
    end
  end

  // receiver stall: random stretches, a long hold-off, or none when random mode is off
  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (hold_off) out_stall <= 1'b1;
      else if (!rx_random) out_stall <= 1'b0;
      else begin
        w = $urandom_range(0, 8);
        if (w != 0 && $urandom_range(0, 3) != 0) begin
          out_stall <= 1'b1;
          repeat (w - 1) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] pick_id(bit known);
    if (known && node_cnt > 0) return ids[$urandom_range(0, node_cnt - 1)];
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    send_word(agd_pkg::REQ_SEARCH, 16'h0001, 16'h0002);      // empty graph: unknown
    send_word(agd_pkg::REQ_ADD_NODE, 16'h0000, 16'h0000);
    send_word(agd_pkg::REQ_ADD_NODE, 16'hFFFF, 16'hFFFF);
    send_word(agd_pkg::REQ_ADD_NODE, 16'hFFFF, 16'h1234);    // duplicate
    send_word(agd_pkg::REQ_ADD_NODE, 16'h5555, 16'hAAAA);
    send_word(agd_pkg::REQ_ADD_EDGE, 16'h0000, 16'hFFFF);
    send_word(agd_pkg::REQ_ADD_EDGE, 16'h0000, 16'hFFFF);    // repeated edge
    send_word(agd_pkg::REQ_ADD_EDGE, 16'hFFFF, 16'h5555);
    send_word(agd_pkg::REQ_ADD_EDGE, 16'h5555, 16'h0000);
    send_word(agd_pkg::REQ_ADD_EDGE, 16'h0000, 16'h7777);    // unknown dest
    send_word(agd_pkg::REQ_TEST, 16'h0000, 16'hFFFF);
    send_word(agd_pkg::REQ_TEST, 16'hFFFF, 16'h0000);
    send_word(agd_pkg::REQ_DEGREE, 16'h0000, 16'h0000);
    send_word(agd_pkg::REQ_PRED, 16'h5555, 16'h0000);        // no predecessor yet
    send_word(agd_pkg::REQ_SEARCH, 16'h0000, 16'h0000);      // start as target via cycle
    send_word(agd_pkg::REQ_PRED, 16'h0000, 16'h0000);
    send_word(agd_pkg::REQ_PRED, 16'h5555, 16'h0000);
    send_word(agd_pkg::REQ_SEARCH, 16'h0000, 16'h5555);      // visited start
    send_word(agd_pkg::REQ_PRED, 16'hAAAA, 16'h0000);        // unknown
    send_word(REQ_BAD_A, 16'hFFFF, 16'hFFFF);                // unknown request codes
    send_word(REQ_BAD_B, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  // long receiver hold-off while sender keeps offering words
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_word(agd_pkg::REQ_DEGREE, pick_id(1), 16'h0);
    join
    wait_drained();
  endtask

  // fill table to its limit, then a full-table add
  task automatic test_fill();
    while (node_cnt < SLOTS)
      send_word(agd_pkg::REQ_ADD_NODE, 16'($urandom), 16'($urandom));
    send_word(agd_pkg::REQ_ADD_NODE, 16'($urandom), 16'h0);
    wait_drained();
  endtask

  // random phase: small graphs built and searched, plus noise
  task automatic test_random(int count);
    int op;
    logic [15:0] a, b;
    for (int n = 0; n < count; n++) begin
      op = $urandom_range(0, 99);
      a = pick_id($urandom_range(0, 9) != 0);
      b = pick_id($urandom_range(0, 9) != 0);
      if (op < 12)
        send_word(agd_pkg::REQ_ADD_NODE, ($urandom_range(0, 4) == 0) ? a : 16'($urandom), b);
      else if (op < 45) send_word(agd_pkg::REQ_ADD_EDGE, a, b);
      else if (op < 55) send_word(agd_pkg::REQ_TEST, a, b);
      else if (op < 75) send_word(agd_pkg::REQ_SEARCH, a, b);
      else if (op < 87) send_word(agd_pkg::REQ_PRED, a, b);
      else if (op < 97) send_word(agd_pkg::REQ_DEGREE, a, b);
      else send_word(($urandom_range(0, 1) != 0) ? REQ_BAD_B : REQ_BAD_A, a, b);
      if (n % 300 == 150) wait_drained();   // sender pause until all results are in
    end
    wait_drained();
  endtask

  initial begin
    node_cnt = 0;
    edge_cnt = 0;
    marks = '0;
    pred_ok = '0;
    for (int i = 0; i < SLOTS; i++) begin
      ids[i] = '0;
      rows[i] = '0;
      degs[i] = '0;
      preds[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(600);
    test_fill();
    test_random(550);
    rx_random = 1'b0;
    test_random(50);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
